[design/dzms_pkg.sv]
// ----------------------------------------------------------------------------
// dzms_pkg
// Shared types and constants for the diagonal zigzag matrix scan block.
// ----------------------------------------------------------------------------
package dzms_pkg;

    // Width of the row and column count registers.
    localparam int CNT_W = 5;
    // Width of element counters; holds up to 31 * 31 elements.
    localparam int TOTAL_W = 2 * CNT_W;
    // Widths of the payload fields.
    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;

    // Configuration register indexes.
    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    // Input word operation codes.
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    // Input word.
    typedef struct packed {
        logic                      func;
        logic signed [VALUE_W-1:0] elem_value;
    } in_word_t;

    // Output word.
    typedef struct packed {
        logic signed [VALUE_W-1:0] out_value;
        logic [POS_W-1:0]          out_row;
        logic [POS_W-1:0]          out_col;
        logic                      is_final;
    } out_word_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic read;
        logic capture;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_ok;
        logic out_busy;
    } dp_status_t;

endpackage

[design/dzms_ram.sv]
// ----------------------------------------------------------------------------
// dzms_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dzms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/dzms_ctrl.sv]
// ----------------------------------------------------------------------------
// dzms_ctrl
// Controller: accepts input words and sequences the store read.
// ----------------------------------------------------------------------------
module dzms_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_func,
    output logic                 in_stall,
    input  dzms_pkg::dp_status_t status,
    output dzms_pkg::dp_cmd_t    cmd
);

    import dzms_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        in_stall    = 1'b1;
        cmd.load    = 1'b0;
        cmd.read    = 1'b0;
        cmd.capture = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (in_func == FUNC_LOAD)
                    begin
                        cmd.load = 1'b1;
                    end
                    else if (status.scan_ok)
                    begin
                        // A request with data to give starts a store read.
                        cmd.read   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // Move the read data out once the output register is free.
                if (!status.out_busy)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/dzms_datapath.sv]
// ----------------------------------------------------------------------------
// dzms_datapath
// Datapath: configuration, load and scan counters, the zigzag position
// walk, the element store and the output register.
// ----------------------------------------------------------------------------
module dzms_datapath #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16,
    parameter int DATA_W   = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [dzms_pkg::CNT_W-1:0]        cfg_data,
    input  logic signed [dzms_pkg::VALUE_W-1:0] elem_value,
    input  dzms_pkg::dp_cmd_t                 cmd,
    output dzms_pkg::dp_status_t              status,
    input  logic                              out_stall,
    output logic                              out_valid,
    output dzms_pkg::out_word_t               out_data
);

    import dzms_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROWS_LIM = (MAX_ROWS < (2 ** CNT_W - 1)) ? MAX_ROWS : (2 ** CNT_W - 1);
    localparam int COLS_LIM = (MAX_COLS < (2 ** CNT_W - 1)) ? MAX_COLS : (2 ** CNT_W - 1);

    logic [CNT_W-1:0]   row_count_reg;
    logic [CNT_W-1:0]   col_count_reg;
    logic [TOTAL_W-1:0] load_count_reg;
    logic [TOTAL_W-1:0] emit_count_reg;
    logic [CNT_W-1:0]   scan_row_reg;
    logic [CNT_W-1:0]   scan_col_reg;
    logic               going_up_reg;
    logic [POS_W-1:0]   pend_row_reg;
    logic [POS_W-1:0]   pend_col_reg;
    logic               pend_final_reg;
    logic               out_valid_reg;
    out_word_t          out_data_reg;

    logic [CNT_W-1:0]   rows;
    logic [CNT_W-1:0]   cols;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] emit_inc;
    logic [TOTAL_W-1:0] scan_addr;
    logic               load_room;
    logic [CNT_W-1:0]   scan_row_next;
    logic [CNT_W-1:0]   scan_col_next;
    logic               going_up_next;
    logic [DATA_W-1:0]  rd_data;

    // Effective dimensions: zero reads as one, large values clamp.
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows = CNT_W'(1);
        end
        else if (int'(row_count_reg) > ROWS_LIM)
        begin
            rows = CNT_W'(ROWS_LIM);
        end
        else
        begin
            rows = row_count_reg;
        end

        if (col_count_reg == '0)
        begin
            cols = CNT_W'(1);
        end
        else if (int'(col_count_reg) > COLS_LIM)
        begin
            cols = CNT_W'(COLS_LIM);
        end
        else
        begin
            cols = col_count_reg;
        end
    end

    assign total     = TOTAL_W'(rows) * TOTAL_W'(cols);
    assign emit_inc  = emit_count_reg + TOTAL_W'(1);
    assign scan_addr = TOTAL_W'(scan_row_reg) * TOTAL_W'(cols) + TOTAL_W'(scan_col_reg);
    assign load_room = (load_count_reg < total);

    assign status.scan_ok  = !load_room && (emit_count_reg < total);
    assign status.out_busy = out_valid_reg && out_stall;

    // Next position of the zigzag walk.
    always_comb
    begin
        scan_row_next = scan_row_reg;
        scan_col_next = scan_col_reg;
        going_up_next = going_up_reg;
        if (going_up_reg)
        begin
            if (scan_col_reg == cols - CNT_W'(1))
            begin
                scan_row_next = scan_row_reg + CNT_W'(1);
                going_up_next = 1'b0;
            end
            else if (scan_row_reg == '0)
            begin
                scan_col_next = scan_col_reg + CNT_W'(1);
                going_up_next = 1'b0;
            end
            else
            begin
                scan_row_next = scan_row_reg - CNT_W'(1);
                scan_col_next = scan_col_reg + CNT_W'(1);
            end
        end
        else
        begin
            if (scan_row_reg == rows - CNT_W'(1))
            begin
                scan_col_next = scan_col_reg + CNT_W'(1);
                going_up_next = 1'b1;
            end
            else if (scan_col_reg == '0)
            begin
                scan_row_next = scan_row_reg + CNT_W'(1);
                going_up_next = 1'b1;
            end
            else
            begin
                scan_row_next = scan_row_reg + CNT_W'(1);
                scan_col_next = scan_col_reg - CNT_W'(1);
            end
        end
    end

    // Configuration, counters and scan position.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= CNT_W'(16);
            col_count_reg  <= CNT_W'(16);
            load_count_reg <= '0;
            emit_count_reg <= '0;
            scan_row_reg   <= '0;
            scan_col_reg   <= '0;
            going_up_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            // A configuration write restarts loading and scanning.
            if (cfg_index == CFG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data;
            end
            else
            begin
                col_count_reg <= cfg_data;
            end
            load_count_reg <= '0;
            emit_count_reg <= '0;
            scan_row_reg   <= '0;
            scan_col_reg   <= '0;
            going_up_reg   <= 1'b1;
        end
        else if (cmd.load)
        begin
            if (load_room)
            begin
                load_count_reg <= load_count_reg + TOTAL_W'(1);
            end
        end
        else if (cmd.read)
        begin
            if (emit_inc >= total)
            begin
                // Last element: return to the empty state.
                load_count_reg <= '0;
                emit_count_reg <= '0;
                scan_row_reg   <= '0;
                scan_col_reg   <= '0;
                going_up_reg   <= 1'b1;
            end
            else
            begin
                emit_count_reg <= emit_inc;
                scan_row_reg   <= scan_row_next;
                scan_col_reg   <= scan_col_next;
                going_up_reg   <= going_up_next;
            end
        end
    end

    // Position and final flag of the element being read.
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            pend_row_reg   <= scan_row_reg[POS_W-1:0];
            pend_col_reg   <= scan_col_reg[POS_W-1:0];
            pend_final_reg <= (emit_inc == total);
        end
    end

    // Element store.
    dzms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.load && load_room),
        .waddr (ADDR_W'(load_count_reg)),
        .wdata (DATA_W'($unsigned(elem_value))),
        .re    (cmd.read),
        .raddr (ADDR_W'(scan_addr)),
        .rdata (rd_data)
    );

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            out_data_reg.out_value <= VALUE_W'(rd_data);
            out_data_reg.out_row   <= pend_row_reg;
            out_data_reg.out_col   <= pend_col_reg;
            out_data_reg.is_final  <= pend_final_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[design/diagonal_zigzag_matrix_scan_core.sv]
// ----------------------------------------------------------------------------
// diagonal_zigzag_matrix_scan_core
// Loads a matrix row by row and reads it back in diagonal zigzag order.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, in_data) carries one word per
// accepted handshake. A word with func 0 loads the next matrix element in
// row-major order; loads beyond rows*cols are dropped. A word with func 1
// asks for the next element in zigzag order; it is dropped if the matrix is
// not fully loaded. The output channel (out_valid, out_stall, out_data)
// returns value, row, column and a final flag. After the final element the
// block is empty and ready for a new matrix.
// Loads stream at one word per cycle while in_stall is low. A request that
// yields a result is read from the store, a memory with a registered read
// port, and in_stall is high while the block waits in the read state. The
// result moves into the output register once that register is free.
// If the receiver stalls, the output register holds its word; one more
// request can be read from the store, then the input stalls until the
// output register frees up. Loads keep flowing while only the output register holds a result.
// Reset sets both counts to 16 and empties the matrix; store contents are
// undefined until loaded. Configuration writes restart loading and scanning;
// the user makes them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module diagonal_zigzag_matrix_scan_core #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16,
    parameter int DATA_W   = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  dzms_pkg::in_word_t         in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output dzms_pkg::out_word_t        out_data,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [dzms_pkg::CNT_W-1:0] cfg_data
);

    import dzms_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Controller.
    dzms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_func  (in_data.func),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath.
    dzms_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .DATA_W   (DATA_W)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .elem_value (in_data.elem_value),
        .cmd        (cmd),
        .status     (status),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .out_data   (out_data)
    );

endmodule
